// ===== hdl/sc1kbd_pkg.sv =====
// ---------------------------------------------------------------------------
// sc1kbd_pkg
// Shared types, scancode constants and the set 1 decode table for the
// keyboard character FIFO.
// ---------------------------------------------------------------------------
package sc1kbd_pkg;

   localparam logic [7:0] PREFIX_EXT = 8'hE0;
   localparam logic [7:0] ARROW_UP   = 8'h48;
   localparam logic [7:0] ARROW_DOWN = 8'h50;
   localparam logic [7:0] ARROW_LEFT = 8'h4B;
   localparam logic [7:0] ARROW_RIGHT = 8'h4D;

   localparam logic [6:0] CHAR_W = 7'h77;
   localparam logic [6:0] CHAR_S = 7'h73;
   localparam logic [6:0] CHAR_A = 7'h61;
   localparam logic [6:0] CHAR_D = 7'h64;

   localparam int CHAR_BITS = 7;

   // US QWERTY make codes 0x00..0x39, padded with zero up to 0x3F
   localparam logic [6:0] QWERTY_TBL [64] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   typedef struct packed {
      logic       operation;
      logic       data_ready;
      logic [7:0] scancode;
   } req_type;

   typedef struct packed {
      logic [6:0] char_out;
      logic       char_valid;
      logic       has_char;
      logic       dropped;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      logic       is_pop;
      logic       push;
      logic [6:0] ch;
   } cmd_type;

endpackage

// ===== hdl/sc1kbd_ram.sv =====
// ---------------------------------------------------------------------------
// sc1kbd_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module sc1kbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sc1kbd_front.sv =====
// ---------------------------------------------------------------------------
// sc1kbd_front
// Accepts requests, tracks the 0xE0 prefix and decodes make codes into
// commands for the back end.
// ---------------------------------------------------------------------------
module sc1kbd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  sc1kbd_pkg::req_type req_data,
   output logic                cmd_valid,
   output sc1kbd_pkg::cmd_type cmd_data
);

   logic       ext_ff;
   logic       ext_in;
   logic       accept;
   logic [6:0] key_ch;

   assign accept = req_valid && req_ready;

   always_comb begin
      key_ch = '0;
      if (ext_ff) begin
         case (req_data.scancode)
            sc1kbd_pkg::ARROW_UP:    key_ch = sc1kbd_pkg::CHAR_W;
            sc1kbd_pkg::ARROW_DOWN:  key_ch = sc1kbd_pkg::CHAR_S;
            sc1kbd_pkg::ARROW_LEFT:  key_ch = sc1kbd_pkg::CHAR_A;
            sc1kbd_pkg::ARROW_RIGHT: key_ch = sc1kbd_pkg::CHAR_D;
            default:                 key_ch = '0;
         endcase
      end else if (req_data.scancode[7:6] == 2'b00) begin
         key_ch = sc1kbd_pkg::QWERTY_TBL[req_data.scancode[5:0]];
      end
   end

   always_comb begin
      cmd_data = '0;
      ext_in   = ext_ff;
      if (accept) begin
         if (req_data.operation) begin
            cmd_data.is_pop = 1'b1;
         end else if (req_data.data_ready) begin
            if (req_data.scancode == sc1kbd_pkg::PREFIX_EXT) begin
               ext_in = 1'b1;
            end else if (!req_data.scancode[7]) begin
               cmd_data.ch   = key_ch;
               cmd_data.push = (key_ch != '0);
               ext_in        = 1'b0;
            end else begin
               ext_in = 1'b0;
            end
         end
      end
   end

   assign cmd_valid = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= 1'b0;
      end else begin
         ext_ff <= ext_in;
      end
   end

endmodule

// ===== hdl/sc1kbd_queue.sv =====
// ---------------------------------------------------------------------------
// sc1kbd_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module sc1kbd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sc1kbd_pkg::cmd_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output sc1kbd_pkg::cmd_type pop_data,
   input  logic                pop_ready
);

   sc1kbd_pkg::cmd_type slot_ff [2];
   logic       wr_idx_ff;
   logic       wr_idx_in;
   logic       rd_idx_ff;
   logic       rd_idx_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_idx_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_idx_in = do_push ? ~wr_idx_ff : wr_idx_ff;
      rd_idx_in = do_pop ? ~rd_idx_ff : rd_idx_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_idx_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/sc1kbd_back.sv =====
// ---------------------------------------------------------------------------
// sc1kbd_back
// Executes push and pop commands on the character ring buffer and holds
// the response register.
// ---------------------------------------------------------------------------
module sc1kbd_back #(
   parameter int DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  sc1kbd_pkg::cmd_type cmd_data,
   output logic                cmd_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sc1kbd_pkg::rsp_type rsp_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W-1:0] wr_nxt;
   logic [PTR_W-1:0] rd_nxt;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             cv_ff;
   logic             cv_in;
   logic             has_ff;
   logic             has_in;
   logic             drop_ff;
   logic             drop_in;
   logic             take;
   logic             ram_we;
   logic             ram_re;
   logic [sc1kbd_pkg::CHAR_BITS-1:0] ram_q;

   assign cmd_ready = !out_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign wr_nxt    = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_nxt    = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      cv_in     = 1'b0;
      drop_in   = 1'b0;
      if (take) begin
         if (cmd_data.is_pop) begin
            if (wr_ptr_ff != rd_ptr_ff) begin
               ram_re    = 1'b1;
               cv_in     = 1'b1;
               rd_ptr_in = rd_nxt;
            end
         end else if (cmd_data.push) begin
            if (wr_nxt == rd_ptr_ff) begin
               drop_in = 1'b1;
            end else begin
               ram_we    = 1'b1;
               wr_ptr_in = wr_nxt;
            end
         end
      end
      has_in = (wr_ptr_in != rd_ptr_in);
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   sc1kbd_ram #(
      .WIDTH (sc1kbd_pkg::CHAR_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (cmd_data.ch),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (take) begin
         cv_ff   <= cv_in;
         has_ff  <= has_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_data.char_out   = cv_ff ? ram_q : '0;
   assign rsp_data.char_valid = cv_ff;
   assign rsp_data.has_char   = has_ff;
   assign rsp_data.dropped    = drop_ff;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= LAST) && (rd_ptr_ff <= LAST))
      else $error("ring pointer out of range");

   a_pop_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.char_valid && rsp_data.dropped))
      else $error("pop result flagged as dropped");

   a_pop_has_ptr_move: assert property (@(posedge clock) disable iff (reset)
      (take && cv_in) |=> ($past(rd_ptr_ff) != rd_ptr_ff))
      else $error("pop did not advance read pointer");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(rsp_data)))
      else $error("response changed while stalled");

endmodule

// ===== hdl/scancode_set1_keyboard_fifo_core.sv =====
// ---------------------------------------------------------------------------
// scancode_set1_keyboard_fifo_core
// PS/2 scancode set 1 decoder feeding a character ring buffer.
// ---------------------------------------------------------------------------
// Each request is either a keyboard event (decoded through the set 1 US
// QWERTY table, with 0xE0-prefixed arrows giving w/s/a/d) or a pop of the
// oldest buffered character; every request yields exactly one response.
// The buffer holds DEPTH-1 characters; a push into a full buffer is flagged
// as dropped. Throughput is one request per clock while responses are not
// stalled: the front decodes at accept, a two-entry queue hands commands
// to the back end, which updates the pointers and issues one RAM access per
// request. A command is registered in a queue slot, then in the response
// register and registered RAM read. The store needs no clearing after reset.
module scancode_set1_keyboard_fifo_core #(
   parameter int DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sc1kbd_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sc1kbd_pkg::rsp_type rsp_data
);

   logic                f_valid;
   sc1kbd_pkg::cmd_type f_data;
   logic                q_valid;
   sc1kbd_pkg::cmd_type q_data;
   logic                q_ready;

   sc1kbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (f_valid),
      .cmd_data  (f_data)
   );

   sc1kbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_data  (f_data),
      .push_ready (req_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop_ready  (q_ready)
   );

   sc1kbd_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_data  (q_data),
      .cmd_ready (q_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/scancode_set1_keyboard_fifo_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scancode_set1_keyboard_fifo_core_test
// Self-checking bench for the set 1 keyboard decoder and character FIFO.
// ---------------------------------------------------------------------------
// Requests go in over a valid/ready channel. Each accepted request updates a
// behavioral copy of the decoder and ring buffer, which predicts the one
// response it causes. Responses are compared field by field, in order.
// Stimulus starts with directed key events, prefixes, releases and pops. A
// random part follows, in phases of PHASE_ITEMS items with varying pop
// shares, some mostly keys to fill the buffer and some mostly pops to drain
// it. Both sides idle at random but for one phase, and the receiver holds
// off once for a long stretch so the block backs up into its request port.
// ---------------------------------------------------------------------------
module scancode_set1_keyboard_fifo_core_test;

   localparam int DEPTH = 128;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 200;
   localparam logic OP_KEY = 1'b0;
   localparam logic OP_POP = 1'b1;
   localparam logic [7:0] RELEASE_BIT = 8'h80;
   localparam logic [7:0] LAST_MAKE = 8'h39;

   localparam logic [6:0] US_KEYMAP [58] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
      7'h00, 7'h20
   };

   class keystroke_fifo_model;
      logic [6:0] char_ring [DEPTH];
      int unsigned wr_idx;
      int unsigned rd_idx;
      bit ext_armed;
      sc1kbd_pkg::rsp_type awaited_rsp [$];
      int errors;
      int pushed_chars;
      int dropped_chars;
      int popped_chars;
      int empty_pops;

      function new();
         wr_idx = 0;
         rd_idx = 0;
         ext_armed = 0;
         errors = 0;
         pushed_chars = 0;
         dropped_chars = 0;
         popped_chars = 0;
         empty_pops = 0;
      endfunction

      function logic [6:0] decode_make(logic [7:0] code, bit extended);
         if (extended) begin
            case (code)
               sc1kbd_pkg::ARROW_UP:    return 7'h77;
               sc1kbd_pkg::ARROW_DOWN:  return 7'h73;
               sc1kbd_pkg::ARROW_LEFT:  return 7'h61;
               sc1kbd_pkg::ARROW_RIGHT: return 7'h64;
               default:                 return 7'h00;
            endcase
         end
         if (code <= LAST_MAKE) return US_KEYMAP[code];
         return 7'h00;
      endfunction

      function void accept_request(sc1kbd_pkg::req_type r);
         sc1kbd_pkg::rsp_type exp;
         logic [6:0] ch;
         int unsigned nxt;
         exp = '0;
         if (r.operation == OP_POP) begin
            if (wr_idx != rd_idx) begin
               exp.char_out = char_ring[rd_idx];
               exp.char_valid = 1'b1;
               rd_idx = (rd_idx + 1) % DEPTH;
               popped_chars++;
            end else begin
               empty_pops++;
            end
         end else if (r.data_ready) begin
            if (r.scancode == sc1kbd_pkg::PREFIX_EXT) begin
               ext_armed = 1;
            end else if ((r.scancode & RELEASE_BIT) == 0) begin
               ch = decode_make(r.scancode, ext_armed);
               if (ch != 0) begin
                  nxt = (wr_idx + 1) % DEPTH;
                  if (nxt == rd_idx) begin
                     exp.dropped = 1'b1;
                     dropped_chars++;
                  end else begin
                     char_ring[wr_idx] = ch;
                     wr_idx = nxt;
                     pushed_chars++;
                  end
               end
               ext_armed = 0;
            end else begin
               ext_armed = 0;
            end
         end
         exp.has_char = (wr_idx != rd_idx);
         awaited_rsp.push_back(exp);
      endfunction

      function void check_response(sc1kbd_pkg::rsp_type got);
         sc1kbd_pkg::rsp_type exp;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         exp = awaited_rsp.pop_front();
         if (got.char_out !== exp.char_out) begin
            $display("%0t: char_out expected %h actual %h", $time, exp.char_out, got.char_out);
            errors++;
         end
         if (got.char_valid !== exp.char_valid) begin
            $display("%0t: char_valid expected %b actual %b", $time, exp.char_valid,
                     got.char_valid);
            errors++;
         end
         if (got.has_char !== exp.has_char) begin
            $display("%0t: has_char expected %b actual %b", $time, exp.has_char, got.has_char);
            errors++;
         end
         if (got.dropped !== exp.dropped) begin
            $display("%0t: dropped expected %b actual %b", $time, exp.dropped, got.dropped);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   sc1kbd_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   sc1kbd_pkg::rsp_type rsp_data;

   keystroke_fifo_model tracker;
   bit no_idle;
   bit hold_request;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int cycles = 0;

   scancode_set1_keyboard_fifo_core #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("scancode_set1_keyboard_fifo_core_test failed");
         $finish;
      end
   end

   function sc1kbd_pkg::req_type key_event(logic ready, logic [7:0] code);
      sc1kbd_pkg::req_type r;
      r.operation = OP_KEY;
      r.data_ready = ready;
      r.scancode = code;
      return r;
   endfunction

   function sc1kbd_pkg::req_type pop_request();
      sc1kbd_pkg::req_type r;
      r.operation = OP_POP;
      r.data_ready = 1'($urandom_range(1));
      r.scancode = 8'($urandom_range(255));
      return r;
   endfunction

   function logic [7:0] arrow_code();
      case ($urandom_range(3))
         0:       return sc1kbd_pkg::ARROW_UP;
         1:       return sc1kbd_pkg::ARROW_DOWN;
         2:       return sc1kbd_pkg::ARROW_LEFT;
         default: return sc1kbd_pkg::ARROW_RIGHT;
      endcase
   endfunction

   task send_request(input sc1kbd_pkg::req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.accept_request(r);
      if (!no_idle && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task send_key(input logic [7:0] code);
      send_request(key_event(1'b1, code));
   endtask

   task send_random_item(input int pop_pct, inout int sent);
      if ($urandom_range(99) < pop_pct) begin
         send_request(pop_request());
         sent++;
         return;
      end
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            send_key(8'($urandom_range(0, LAST_MAKE)));
            sent++;
         end
         5: begin
            send_key(8'($urandom_range(8'h80, 8'hFF)));
            sent++;
         end
         6, 7: begin
            send_key(sc1kbd_pkg::PREFIX_EXT);
            if ($urandom_range(3) != 0) send_key(arrow_code());
            else send_key(8'($urandom_range(8'h00, 8'h7F)));
            sent += 2;
         end
         8: begin
            send_request(key_event(1'b0, 8'($urandom_range(255))));
            sent++;
         end
         default: begin
            send_key(8'($urandom_range(255)));
            sent++;
         end
      endcase
   endtask

   // receiver: checks responses, stalls at random, one long hold-off
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) tracker.check_response(rsp_data);
         if (hold_request && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 37);
         end
      end
   end

   initial begin
      int sent;
      int phase_pop_pct [7] = '{8, 0, 60, 30, 0, 70, 35};
      tracker = new();
      no_idle = 0;
      hold_request = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_request(pop_request());
      send_request(key_event(1'b0, 8'h1E));
      send_key(8'h00);
      send_key(8'h01);
      send_key(8'h0E);
      send_key(LAST_MAKE);
      send_key(8'h3A);
      send_key(8'h7F);
      send_key(sc1kbd_pkg::PREFIX_EXT);
      send_key(sc1kbd_pkg::ARROW_UP);
      send_key(sc1kbd_pkg::PREFIX_EXT);
      send_key(sc1kbd_pkg::PREFIX_EXT);
      send_key(sc1kbd_pkg::ARROW_DOWN);
      send_key(sc1kbd_pkg::PREFIX_EXT);
      send_request(key_event(1'b0, sc1kbd_pkg::ARROW_UP));
      send_key(sc1kbd_pkg::ARROW_LEFT);
      send_key(sc1kbd_pkg::PREFIX_EXT);
      send_key(8'h1C);
      send_key(sc1kbd_pkg::PREFIX_EXT);
      send_key(8'hC8);
      send_key(sc1kbd_pkg::ARROW_RIGHT);
      send_key(8'h9E);
      send_key(8'hFF);
      send_request(pop_request());
      send_request(pop_request());

      // random phases of PHASE_ITEMS items: fill-heavy and drain-heavy pop shares
      for (int p = 0; p < 7; p++) begin
         if (p == 1) hold_request = 1;
         no_idle = (p == 3);
         sent = 0;
         while (sent < PHASE_ITEMS) send_random_item(phase_pop_pct[p], sent);
      end
      no_idle = 0;
      req_valid <= 1'b0;

      while (tracker.awaited_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d pushed and %0d dropped keys, %0d popped chars, %0d empty pops",
               tracker.pushed_chars, tracker.dropped_chars, tracker.popped_chars,
               tracker.empty_pops);
      $display("with extended prefixes, releases, not-ready events and a long output stall");
      if (tracker.errors == 0) begin
         $display("scancode_set1_keyboard_fifo_core_test passed");
      end else begin
         $display("%0d mismatches", tracker.errors);
         $display("scancode_set1_keyboard_fifo_core_test failed");
      end
      $finish;
   end

endmodule
